### rtl/dmsr_pkg.sv
// Shared types, codes and helper functions of the dual motor speed ramp block.
package dmsr_pkg;

    // Field and register widths
    localparam int DUTY_W         = 8;
    localparam int TARGET_W       = 10;
    localparam int CFG_PERIOD_W   = 16;
    localparam int CFG_DATA_W     = 16;
    localparam int CFG_INDEX_W    = 2;
    localparam int TIMER_BITS_DEF = 16;
    localparam int DIRECTION_COUNT = 5;

    // Register reset values
    localparam logic [7:0]              DEADBAND_RST      = 8'd30;
    localparam logic [CFG_PERIOD_W-1:0] CRUISE_PERIOD_RST = 16'd100;
    localparam logic [CFG_PERIOD_W-1:0] ACCEL_PERIOD_RST  = 16'd100;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_DEADBAND      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CRUISE_PERIOD = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACCEL_PERIOD  = 2'd2;

    // Saturation limits of a target
    localparam logic [8:0]                 MAG_SAT = 9'd255;
    localparam logic signed [TARGET_W-1:0] SAT_POS = 10'sd255;
    localparam logic signed [TARGET_W-1:0] SAT_NEG = -10'sd255;
    localparam logic [DUTY_W-1:0]          DUTY_MAX = 8'd255;

    // Bridge pins
    localparam logic [3:0] PIN_LF = 4'b0001;
    localparam logic [3:0] PIN_LB = 4'b0010;
    localparam logic [3:0] PIN_RF = 4'b0100;
    localparam logic [3:0] PIN_RB = 4'b1000;

    typedef enum logic [2:0] {
        OP_CRUISE    = 3'd0,
        OP_ACCEL     = 3'd1,
        OP_DIRECTION = 3'd2,
        OP_SPEED     = 3'd3,
        OP_STOP      = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        DIR_OFF     = 3'd0,
        DIR_FORWARD = 3'd1,
        DIR_BACK    = 3'd2,
        DIR_LEFT    = 3'd3,
        DIR_RIGHT   = 3'd4
    } dir_t;

    typedef enum logic [1:0] {
        MODE_NONE = 2'd0,
        MODE_FWD  = 2'd1,
        MODE_BACK = 2'd2
    } mode_t;

    typedef struct packed {
        logic [2:0]        opcode;
        logic signed [7:0] fade_left;
        logic signed [7:0] fade_right;
        logic [7:0]        speed_left;
        logic [7:0]        speed_right;
        logic [2:0]        direction_code;
    } cmd_item_t;

    typedef struct packed {
        logic [7:0] pwm_left;
        logic [7:0] pwm_right;
        logic [3:0] bridge_pins;
        logic [2:0] current_direction;
    } res_item_t;

    // State of one motor side
    typedef struct packed {
        logic [DUTY_W-1:0]          duty;
        logic signed [TARGET_W-1:0] target;
        mode_t                      mode;
    } side_t;

    // Pin change asked for by one side on a cruise update
    typedef struct packed {
        logic set_fwd;
        logic set_back;
    } pin_req_t;

    // Pin mask of a direction code; codes past the list drive no pins
    function automatic logic [3:0] dir_mask(input logic [2:0] code);
        logic [3:0] mask;
        case (code)
            DIR_FORWARD: mask = PIN_LF | PIN_RF;
            DIR_BACK:    mask = PIN_LB | PIN_RB;
            DIR_LEFT:    mask = PIN_LB | PIN_RF;
            DIR_RIGHT:   mask = PIN_LF | PIN_RB;
            default:     mask = 4'b0000;
        endcase
        return mask;
    endfunction

    // First direction whose mask overlaps the pins, else off
    function automatic logic [2:0] dir_now(input logic [3:0] pins);
        logic [2:0] code;
        code = DIR_OFF;
        if ((pins & dir_mask(DIR_FORWARD)) != 4'b0000)
            code = DIR_FORWARD;
        else if ((pins & dir_mask(DIR_BACK)) != 4'b0000)
            code = DIR_BACK;
        else if ((pins & dir_mask(DIR_LEFT)) != 4'b0000)
            code = DIR_LEFT;
        else if ((pins & dir_mask(DIR_RIGHT)) != 4'b0000)
            code = DIR_RIGHT;
        return code;
    endfunction

endpackage

### rtl/dmsr_side.sv
// Next-state logic of one motor side: cruise update, ramp step and commands.
module dmsr_side (
    input  logic [2:0]         opcode,
    input  logic signed [7:0]  fade,
    input  logic [7:0]         speed,
    input  logic [7:0]         deadband,
    input  logic               cruise_fire,
    input  logic               ramp_fire,
    input  dmsr_pkg::side_t    cur,
    output dmsr_pkg::side_t    nxt,
    output dmsr_pkg::pin_req_t pin_req
);

    logic signed [dmsr_pkg::TARGET_W-1:0] sum;
    logic signed [dmsr_pkg::TARGET_W-1:0] neg_sum;
    logic [8:0]                           mag;
    logic signed [dmsr_pkg::TARGET_W-1:0] duty_ext;
    logic signed [dmsr_pkg::TARGET_W-1:0] speed_ext;

    // Add the fade to the target and take its magnitude
    assign sum       = cur.target + {{2{fade[7]}}, fade};
    assign neg_sum   = -sum;
    assign mag       = sum[dmsr_pkg::TARGET_W-1] ? neg_sum[8:0] : sum[8:0];
    assign duty_ext  = {2'b00, cur.duty};
    assign speed_ext = {2'b00, speed};

    // Work out the side's next state for the decoded command
    always_comb
    begin
        nxt     = cur;
        pin_req = '0;
        unique case (opcode)
            dmsr_pkg::OP_CRUISE:
            begin
                if (cruise_fire)
                begin
                    nxt.target = sum;
                    if (mag < {1'b0, deadband})
                    begin
                        nxt.duty = '0;
                        nxt.mode = dmsr_pkg::MODE_NONE;
                    end
                    else if (mag >= dmsr_pkg::MAG_SAT)
                    begin
                        nxt.duty   = dmsr_pkg::DUTY_MAX;
                        nxt.target = sum[dmsr_pkg::TARGET_W-1] ? dmsr_pkg::SAT_NEG
                                                               : dmsr_pkg::SAT_POS;
                    end
                    else if (!sum[dmsr_pkg::TARGET_W-1])
                    begin
                        nxt.duty = mag[7:0];
                        if (cur.mode != dmsr_pkg::MODE_FWD)
                        begin
                            nxt.mode        = dmsr_pkg::MODE_FWD;
                            pin_req.set_fwd = 1'b1;
                        end
                    end
                    else
                    begin
                        nxt.duty = mag[7:0];
                        if (cur.mode != dmsr_pkg::MODE_BACK)
                        begin
                            nxt.mode         = dmsr_pkg::MODE_BACK;
                            pin_req.set_back = 1'b1;
                        end
                    end
                end
            end
            dmsr_pkg::OP_ACCEL:
            begin
                // Step the duty by one toward a larger target
                if (ramp_fire && (duty_ext < cur.target))
                    nxt.duty = cur.duty + 8'd1;
            end
            dmsr_pkg::OP_DIRECTION:
            begin
                nxt.duty = '0;
            end
            dmsr_pkg::OP_SPEED:
            begin
                // Cut the duty at once, or store a new ramp target
                if (speed < cur.duty)
                    nxt.duty = speed;
                else
                    nxt.target = speed_ext;
            end
            dmsr_pkg::OP_STOP:
            begin
                nxt.duty   = '0;
                nxt.target = '0;
                nxt.mode   = dmsr_pkg::MODE_NONE;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

### rtl/dual_motor_speed_ramp.sv
// Top level of the dual motor speed ramp: state registers, dividers and result buffering.
// For each accepted command item one result item (both duties, the bridge pins and the
// direction they show) comes out, holding the state after that command; a new item can be
// accepted on every clock while cmd_stall is low. Results sit in an output register backed by a
// one-entry skid buffer, so cmd_stall rises only once both are full and res_stall is held.
// The cruise and acceleration dividers count accepted tick commands, saturate at
// 2**TIMER_BITS-1 and fire when the count reaches or passes the programmed period.
// Configuration writes take effect on the next clock and should only be made while the block
// is idle.
module dual_motor_speed_ramp #(
    parameter int TIMER_BITS = dmsr_pkg::TIMER_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cmd_valid,
    output logic                                cmd_stall,
    input  dmsr_pkg::cmd_item_t                 cmd,
    output logic                                res_valid,
    input  logic                                res_stall,
    output dmsr_pkg::res_item_t                 res,
    input  logic                                cfg_we,
    input  logic [dmsr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [dmsr_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CMP_W = (TIMER_BITS > dmsr_pkg::CFG_PERIOD_W) ? TIMER_BITS
                                                                  : dmsr_pkg::CFG_PERIOD_W;

    // Configuration registers
    logic [7:0]                        deadband_reg;
    logic [dmsr_pkg::CFG_PERIOD_W-1:0] cruise_period_reg;
    logic [dmsr_pkg::CFG_PERIOD_W-1:0] accel_period_reg;

    // Block state
    dmsr_pkg::side_t       left_reg, left_next;
    dmsr_pkg::side_t       right_reg, right_next;
    logic [3:0]            pins_reg, pins_next;
    logic [TIMER_BITS-1:0] cruise_cnt_reg, cruise_cnt_next;
    logic [TIMER_BITS-1:0] ramp_cnt_reg, ramp_cnt_next;

    // Result buffering
    logic                  out_valid_reg;
    dmsr_pkg::res_item_t   out_reg;
    logic                  skid_valid_reg;
    dmsr_pkg::res_item_t   skid_reg;

    logic                  cmd_fire;
    logic                  out_free;
    logic                  cruise_fire;
    logic                  ramp_fire;
    logic                  cruise_due;
    logic                  ramp_due;
    dmsr_pkg::pin_req_t    left_req;
    dmsr_pkg::pin_req_t    right_req;
    dmsr_pkg::res_item_t   result;

    assign cmd_stall = skid_valid_reg;
    assign cmd_fire  = cmd_valid && !cmd_stall;
    assign out_free  = !out_valid_reg || !res_stall;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    // Divider compares against the programmed periods
    assign cruise_due  = CMP_W'(cruise_cnt_reg) >= CMP_W'(cruise_period_reg);
    assign ramp_due    = CMP_W'(ramp_cnt_reg) >= CMP_W'(accel_period_reg);
    assign cruise_fire = (cmd.opcode == dmsr_pkg::OP_CRUISE) && cruise_due;
    assign ramp_fire   = (cmd.opcode == dmsr_pkg::OP_ACCEL) && ramp_due
                         && (dmsr_pkg::dir_now(pins_reg) != dmsr_pkg::DIR_OFF);

    dmsr_side u_left (
        .opcode      (cmd.opcode),
        .fade        (cmd.fade_left),
        .speed       (cmd.speed_left),
        .deadband    (deadband_reg),
        .cruise_fire (cruise_fire),
        .ramp_fire   (ramp_fire),
        .cur         (left_reg),
        .nxt         (left_next),
        .pin_req     (left_req)
    );

    dmsr_side u_right (
        .opcode      (cmd.opcode),
        .fade        (cmd.fade_right),
        .speed       (cmd.speed_right),
        .deadband    (deadband_reg),
        .cruise_fire (cruise_fire),
        .ramp_fire   (ramp_fire),
        .cur         (right_reg),
        .nxt         (right_next),
        .pin_req     (right_req)
    );

    // Work out pins and divider counts for the command
    always_comb
    begin
        pins_next       = pins_reg;
        cruise_cnt_next = cruise_cnt_reg;
        ramp_cnt_next   = ramp_cnt_reg;
        case (cmd.opcode)
            dmsr_pkg::OP_CRUISE:
            begin
                if (cruise_due)
                    cruise_cnt_next = '0;
                else if (!(&cruise_cnt_reg))
                    cruise_cnt_next = cruise_cnt_reg + 1'b1;
                if (left_req.set_fwd)
                    pins_next = (pins_next & ~dmsr_pkg::PIN_LB) | dmsr_pkg::PIN_LF;
                if (left_req.set_back)
                    pins_next = (pins_next & ~dmsr_pkg::PIN_LF) | dmsr_pkg::PIN_LB;
                if (right_req.set_fwd)
                    pins_next = (pins_next & ~dmsr_pkg::PIN_RB) | dmsr_pkg::PIN_RF;
                if (right_req.set_back)
                    pins_next = (pins_next & ~dmsr_pkg::PIN_RF) | dmsr_pkg::PIN_RB;
            end
            dmsr_pkg::OP_ACCEL:
            begin
                if (ramp_fire)
                    ramp_cnt_next = '0;
                else if (!(&ramp_cnt_reg))
                    ramp_cnt_next = ramp_cnt_reg + 1'b1;
            end
            dmsr_pkg::OP_DIRECTION:
            begin
                pins_next = dmsr_pkg::dir_mask(cmd.direction_code);
            end
            default:
            begin
                pins_next = pins_reg;
            end
        endcase
    end

    // Assemble the result from the state after the command
    always_comb
    begin
        result.pwm_left          = left_next.duty;
        result.pwm_right         = right_next.duty;
        result.bridge_pins       = pins_next;
        result.current_direction = dmsr_pkg::dir_now(pins_next);
    end

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadband_reg      <= dmsr_pkg::DEADBAND_RST;
            cruise_period_reg <= dmsr_pkg::CRUISE_PERIOD_RST;
            accel_period_reg  <= dmsr_pkg::ACCEL_PERIOD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dmsr_pkg::CFG_DEADBAND:      deadband_reg      <= cfg_data[7:0];
                dmsr_pkg::CFG_CRUISE_PERIOD: cruise_period_reg <= cfg_data;
                dmsr_pkg::CFG_ACCEL_PERIOD:  accel_period_reg  <= cfg_data;
                default:                     deadband_reg      <= deadband_reg;
            endcase
        end
    end

    // Advance the state on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg       <= '{duty: '0, target: '0, mode: dmsr_pkg::MODE_NONE};
            right_reg      <= '{duty: '0, target: '0, mode: dmsr_pkg::MODE_NONE};
            pins_reg       <= '0;
            cruise_cnt_reg <= '0;
            ramp_cnt_reg   <= '0;
        end
        else if (cmd_fire)
        begin
            left_reg       <= left_next;
            right_reg      <= right_next;
            pins_reg       <= pins_next;
            cruise_cnt_reg <= cruise_cnt_next;
            ramp_cnt_reg   <= ramp_cnt_next;
        end
    end

    // Hold results in the output register, spilling into the skid stage when stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= cmd_fire;
            end
        end
        else if (cmd_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Result payloads
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (cmd_fire)
                out_reg <= result;
        end
        else if (cmd_fire)
        begin
            skid_reg <= result;
        end
    end

endmodule

### rtl/dmsr_checker.sv
// Port-level checks of the dual motor speed ramp and their binding to the top level.
module dmsr_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             cmd_valid,
    input logic                             cmd_stall,
    input dmsr_pkg::cmd_item_t              cmd,
    input logic                             res_valid,
    input logic                             res_stall,
    input dmsr_pkg::res_item_t              res
);

    logic out_free;
    logic [2:0] dir_expect;

    assign out_free   = !res_valid || !res_stall;
    assign dir_expect = dmsr_pkg::dir_now(res.bridge_pins);

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("result changed while stalled");

    // Commands back up only behind a waiting result
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> res_valid)
        else $error("command stalled with no result pending");

    // Reported direction follows the bridge pins
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res.current_direction == dir_expect)
        else $error("direction does not match bridge pins");

    // A stop shows both duties at zero in the next result
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall && out_free && cmd.opcode == dmsr_pkg::OP_STOP
        |=> res_valid && res.pwm_left == 8'd0 && res.pwm_right == 8'd0)
        else $error("stop left a duty running");

    // A direction code past the list clears the pins and both duties
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall && out_free && cmd.opcode == dmsr_pkg::OP_DIRECTION
        && cmd.direction_code > dmsr_pkg::DIR_RIGHT
        |=> res_valid && res.bridge_pins == 4'b0000 && res.pwm_left == 8'd0
            && res.pwm_right == 8'd0)
        else $error("unknown direction did not switch off");

endmodule

bind dual_motor_speed_ramp dmsr_checker u_dmsr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);

### tb/testbench.sv
// Self-checking testbench for the dual motor speed ramp: predicted outputs, random traffic.
`timescale 1ns / 1ps

module testbench;

    localparam int STALL_LIMIT = 2000;
    localparam int BURST_TICKS = 40;

    // Predicts the outputs of the drive and checks each result item against them
    class drive_scoreboard;
        logic [7:0]          deadband;
        logic [15:0]         cruise_period;
        logic [15:0]         accel_period;
        logic [7:0]          duty [2];
        int                  target [2];
        dmsr_pkg::mode_t     side_mode [2];
        logic [3:0]          pins;
        logic [15:0]         cruise_cnt;
        logic [15:0]         ramp_cnt;
        dmsr_pkg::res_item_t expected_outputs [$];
        int                  mismatches;
        int                  items_seen;
        int                  results_seen;
        int                  cruise_updates;
        int                  ramp_steps;
        int                  deadbands;
        int                  saturations;

        function new();
            deadband      = dmsr_pkg::DEADBAND_RST;
            cruise_period = dmsr_pkg::CRUISE_PERIOD_RST;
            accel_period  = dmsr_pkg::ACCEL_PERIOD_RST;
            for (int s = 0; s < 2; s++)
            begin
                duty[s]      = '0;
                target[s]    = 0;
                side_mode[s] = dmsr_pkg::MODE_NONE;
            end
            pins           = '0;
            cruise_cnt     = '0;
            ramp_cnt       = '0;
            mismatches     = 0;
            items_seen     = 0;
            results_seen   = 0;
            cruise_updates = 0;
            ramp_steps     = 0;
            deadbands      = 0;
            saturations    = 0;
        endfunction

        function logic [3:0] pins_for(logic [2:0] code);
            case (code)
                dmsr_pkg::DIR_FORWARD: return dmsr_pkg::PIN_LF | dmsr_pkg::PIN_RF;
                dmsr_pkg::DIR_BACK:    return dmsr_pkg::PIN_LB | dmsr_pkg::PIN_RB;
                dmsr_pkg::DIR_LEFT:    return dmsr_pkg::PIN_LB | dmsr_pkg::PIN_RF;
                dmsr_pkg::DIR_RIGHT:   return dmsr_pkg::PIN_LF | dmsr_pkg::PIN_RB;
                default:               return 4'b0000;
            endcase
        endfunction

        // Lowest direction code whose pins are lit
        function logic [2:0] shown_direction();
            for (int d = int'(dmsr_pkg::DIR_FORWARD); d <= int'(dmsr_pkg::DIR_RIGHT); d++)
                if ((pins & pins_for(3'(d))) != 4'b0000)
                    return 3'(d);
            return dmsr_pkg::DIR_OFF;
        endfunction

        function logic [15:0] count_up(logic [15:0] c);
            return (c == 16'hFFFF) ? c : c + 16'd1;
        endfunction

        // Add the fade to one side, then apply deadband, saturation and sign change
        function void cruise_side(int s, int fade, logic [3:0] fwd_pin, logic [3:0] back_pin);
            int t;
            int mag;
            t   = target[s] + fade;
            mag = (t < 0) ? -t : t;
            if (mag < int'(deadband))
            begin
                duty[s]      = '0;
                side_mode[s] = dmsr_pkg::MODE_NONE;
                deadbands++;
            end
            else if (mag >= int'(dmsr_pkg::MAG_SAT))
            begin
                duty[s] = dmsr_pkg::DUTY_MAX;
                t       = (t > 0) ? int'(dmsr_pkg::SAT_POS) : int'(dmsr_pkg::SAT_NEG);
                saturations++;
            end
            else if (t >= 0)
            begin
                if (side_mode[s] != dmsr_pkg::MODE_FWD)
                begin
                    side_mode[s] = dmsr_pkg::MODE_FWD;
                    pins         = (pins & ~back_pin) | fwd_pin;
                end
                duty[s] = 8'(t);
            end
            else
            begin
                if (side_mode[s] != dmsr_pkg::MODE_BACK)
                begin
                    side_mode[s] = dmsr_pkg::MODE_BACK;
                    pins         = (pins & ~fwd_pin) | back_pin;
                end
                duty[s] = 8'(-t);
            end
            target[s] = t;
        endfunction

        // Advance the state by one accepted item and queue the outputs it leaves
        function void predict_outputs(dmsr_pkg::cmd_item_t c);
            dmsr_pkg::res_item_t e;
            items_seen++;
            case (c.opcode)
                dmsr_pkg::OP_CRUISE:
                begin
                    if (cruise_cnt >= cruise_period)
                    begin
                        cruise_side(0, int'($signed(c.fade_left)),
                                    dmsr_pkg::PIN_LF, dmsr_pkg::PIN_LB);
                        cruise_side(1, int'($signed(c.fade_right)),
                                    dmsr_pkg::PIN_RF, dmsr_pkg::PIN_RB);
                        cruise_cnt = '0;
                        cruise_updates++;
                    end
                    else
                        cruise_cnt = count_up(cruise_cnt);
                end
                dmsr_pkg::OP_ACCEL:
                begin
                    if (shown_direction() != dmsr_pkg::DIR_OFF && ramp_cnt >= accel_period)
                    begin
                        for (int s = 0; s < 2; s++)
                            if (int'(duty[s]) < target[s])
                                duty[s] = duty[s] + 8'd1;
                        ramp_cnt = '0;
                        ramp_steps++;
                    end
                    else
                        ramp_cnt = count_up(ramp_cnt);
                end
                dmsr_pkg::OP_DIRECTION:
                begin
                    duty[0] = '0;
                    duty[1] = '0;
                    pins    = pins_for(c.direction_code);
                end
                dmsr_pkg::OP_SPEED:
                begin
                    if (c.speed_left < duty[0])
                        duty[0] = c.speed_left;
                    else
                        target[0] = int'(c.speed_left);
                    if (c.speed_right < duty[1])
                        duty[1] = c.speed_right;
                    else
                        target[1] = int'(c.speed_right);
                end
                dmsr_pkg::OP_STOP:
                begin
                    for (int s = 0; s < 2; s++)
                    begin
                        target[s]    = 0;
                        side_mode[s] = dmsr_pkg::MODE_NONE;
                        duty[s]      = '0;
                    end
                end
                default:
                begin
                end
            endcase
            e.pwm_left          = duty[0];
            e.pwm_right         = duty[1];
            e.bridge_pins       = pins;
            e.current_direction = shown_direction();
            expected_outputs.push_back(e);
        endfunction

        // Compare a result item with the oldest prediction
        function void check_result(dmsr_pkg::res_item_t r);
            dmsr_pkg::res_item_t e;
            results_seen++;
            if (expected_outputs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d arrived with nothing expected: %s %0d/%0d pins %b dir %0d",
                             results_seen, "pwm", r.pwm_left, r.pwm_right, r.bridge_pins,
                             r.current_direction);
                return;
            end
            e = expected_outputs.pop_front();
            if (r.pwm_left !== e.pwm_left || r.pwm_right !== e.pwm_right ||
                r.bridge_pins !== e.bridge_pins || r.current_direction !== e.current_direction)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: expected pwm %0d/%0d pins %b dir %0d, %s %0d/%0d %s %b %s %0d",
                             results_seen, e.pwm_left, e.pwm_right, e.bridge_pins,
                             e.current_direction, "got pwm", r.pwm_left, r.pwm_right,
                             "pins", r.bridge_pins, "dir", r.current_direction);
            end
        endfunction

        function int pending();
            return expected_outputs.size();
        endfunction
    endclass

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             cmd_valid = 1'b0;
    logic                             cmd_stall;
    dmsr_pkg::cmd_item_t              cmd = '0;
    logic                             res_valid;
    logic                             res_stall = 1'b0;
    dmsr_pkg::res_item_t              res;
    logic                             cfg_we = 1'b0;
    logic [dmsr_pkg::CFG_INDEX_W-1:0] cfg_index = dmsr_pkg::CFG_DEADBAND;
    logic [dmsr_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    drive_scoreboard sb;
    logic            quiet = 1'b0;
    int              idle_cycles = 0;

    dual_motor_speed_ramp dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock
    initial
    begin
        forever #4 clk = ~clk;
    end

    // Draw the wait before the next item on either side
    function automatic int draw_gap();
        return quiet ? 0 : $urandom_range(0, 12);
    endfunction

    function automatic dmsr_pkg::cmd_item_t make_cmd(logic [2:0] op, logic [7:0] fl,
                                                     logic [7:0] fr, logic [7:0] sl,
                                                     logic [7:0] sr, logic [2:0] dir);
        dmsr_pkg::cmd_item_t c;
        c.opcode         = op;
        c.fade_left      = fl;
        c.fade_right     = fr;
        c.speed_left     = sl;
        c.speed_right    = sr;
        c.direction_code = dir;
        return c;
    endfunction

    // Weighted toward ticks and active directions so ramps and cruise updates happen often
    function automatic dmsr_pkg::cmd_item_t random_item();
        dmsr_pkg::cmd_item_t c;
        int                  pick;
        c.speed_left  = 8'($urandom);
        c.speed_right = 8'($urandom);
        if ($urandom_range(0, 1) == 0)
        begin
            c.fade_left  = 8'($urandom_range(0, 40) - 20);
            c.fade_right = 8'($urandom_range(0, 40) - 20);
        end
        else
        begin
            c.fade_left  = 8'($urandom);
            c.fade_right = 8'($urandom);
        end
        if ($urandom_range(0, 4) != 0)
            c.direction_code = 3'($urandom_range(int'(dmsr_pkg::DIR_FORWARD),
                                                 int'(dmsr_pkg::DIR_RIGHT)));
        else
            c.direction_code = 3'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 30)
            c.opcode = dmsr_pkg::OP_CRUISE;
        else if (pick < 65)
            c.opcode = dmsr_pkg::OP_ACCEL;
        else if (pick < 75)
            c.opcode = dmsr_pkg::OP_DIRECTION;
        else if (pick < 90)
            c.opcode = dmsr_pkg::OP_SPEED;
        else if (pick < 95)
            c.opcode = dmsr_pkg::OP_STOP;
        else
            c.opcode = 3'($urandom_range(int'(dmsr_pkg::OP_STOP) + 1, 7));
        return c;
    endfunction

    // Offer one item after a drawn gap and hold it until taken
    task automatic send_cmd(input dmsr_pkg::cmd_item_t c);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd       <= c;
        cmd_valid <= 1'b1;
        do @(posedge clk); while (cmd_stall);
        sb.predict_outputs(c);
    endtask

    // Drop valid and wait for every predicted result to come back
    task automatic drain();
        cmd_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    // Program all three registers, one per clock
    task automatic write_config(input logic [7:0] min_spd, input logic [15:0] cruise_p,
                                input logic [15:0] accel_p);
        cfg_we    <= 1'b1;
        cfg_index <= dmsr_pkg::CFG_DEADBAND;
        cfg_data  <= {8'd0, min_spd};
        @(posedge clk);
        cfg_index <= dmsr_pkg::CFG_CRUISE_PERIOD;
        cfg_data  <= cruise_p;
        @(posedge clk);
        cfg_index <= dmsr_pkg::CFG_ACCEL_PERIOD;
        cfg_data  <= accel_p;
        @(posedge clk);
        cfg_we           <= 1'b0;
        sb.deadband      = min_spd;
        sb.cruise_period = cruise_p;
        sb.accel_period  = accel_p;
    endtask

    task automatic random_phase(input logic [7:0] min_spd, input logic [15:0] cruise_p,
                                input logic [15:0] accel_p, input int count);
        write_config(min_spd, cruise_p, accel_p);
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            send_cmd(random_item());
        end
        drain();
        quiet = 1'b0;
    endtask

    // Receiver: stall for a drawn number of cycles, then take one result item
    initial
    begin
        int gap;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            gap = draw_gap();
            if (gap > 0)
            begin
                res_stall <= 1'b1;
                repeat (gap) @(posedge clk);
                res_stall <= 1'b0;
            end
            do @(posedge clk); while (!(res_valid && !res_stall));
        end
    end

    // Check every accepted result
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
            sb.check_result(res);
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        dmsr_pkg::cmd_item_t c;
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero periods, so cruise ticks always fire and accel ticks fire whenever pins are driven
        write_config(8'd30, 16'd0, 16'd0);
        for (int k = 1; k <= 3; k++)
            send_cmd(make_cmd(3'(int'(dmsr_pkg::OP_STOP) + k), 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                              3'b111));
        send_cmd(make_cmd(dmsr_pkg::OP_ACCEL, 8'h00, 8'h00, 8'h00, 8'h00, dmsr_pkg::DIR_OFF));
        for (int d = 0; d < 8; d++)
            send_cmd(make_cmd(dmsr_pkg::OP_DIRECTION, 8'h00, 8'h00, 8'h00, 8'h00, 3'(d)));
        send_cmd(make_cmd(dmsr_pkg::OP_CRUISE, 8'sd127, 8'sd127, 8'h00, 8'h00,
                          dmsr_pkg::DIR_OFF));
        send_cmd(make_cmd(dmsr_pkg::OP_CRUISE, 8'sd127, -8'sd128, 8'h00, 8'h00,
                          dmsr_pkg::DIR_OFF));
        send_cmd(make_cmd(dmsr_pkg::OP_CRUISE, 8'sd127, -8'sd128, 8'h00, 8'h00,
                          dmsr_pkg::DIR_OFF));
        send_cmd(make_cmd(dmsr_pkg::OP_CRUISE, -8'sd128, -8'sd128, 8'h00, 8'h00,
                          dmsr_pkg::DIR_OFF));
        send_cmd(make_cmd(dmsr_pkg::OP_SPEED, 8'h00, 8'h00, 8'd0, 8'd255, dmsr_pkg::DIR_OFF));
        send_cmd(make_cmd(dmsr_pkg::OP_ACCEL, 8'h00, 8'h00, 8'h00, 8'h00, dmsr_pkg::DIR_OFF));
        send_cmd(make_cmd(dmsr_pkg::OP_DIRECTION, 8'h00, 8'h00, 8'h00, 8'h00,
                          dmsr_pkg::DIR_FORWARD));
        send_cmd(make_cmd(dmsr_pkg::OP_ACCEL, 8'h00, 8'h00, 8'h00, 8'h00, dmsr_pkg::DIR_OFF));
        send_cmd(make_cmd(dmsr_pkg::OP_CRUISE, -8'sd128, 8'sd0, 8'h00, 8'h00,
                          dmsr_pkg::DIR_OFF));
        send_cmd(make_cmd(dmsr_pkg::OP_CRUISE, -8'sd128, 8'sd0, 8'h00, 8'h00,
                          dmsr_pkg::DIR_OFF));
        send_cmd(make_cmd(dmsr_pkg::OP_ACCEL, 8'h00, 8'h00, 8'h00, 8'h00, dmsr_pkg::DIR_OFF));
        send_cmd(make_cmd(dmsr_pkg::OP_STOP, 8'h00, 8'h00, 8'h00, 8'h00, dmsr_pkg::DIR_OFF));
        send_cmd(make_cmd(dmsr_pkg::OP_SPEED, 8'h00, 8'h00, 8'd255, 8'd255,
                          dmsr_pkg::DIR_OFF));
        drain();

        // Random traffic under a spread of settings, extremes first
        random_phase(8'd0, 16'd0, 16'd0, 100);
        random_phase(8'd255, 16'd1, 16'd3, 100);
        random_phase(8'($urandom_range(0, 60)), 16'($urandom_range(0, 4)),
                     16'($urandom_range(0, 4)), 100);
        random_phase(8'($urandom_range(0, 255)), 16'($urandom_range(0, 4)),
                     16'($urandom_range(0, 4)), 100);
        random_phase(8'($urandom_range(0, 40)), 16'($urandom_range(0, 2)),
                     16'($urandom_range(0, 8)), 100);

        // Longest periods: both dividers count back to back and never fire
        write_config(8'($urandom_range(0, 60)), 16'hFFFF, 16'hFFFF);
        quiet = 1'b1;
        for (int i = 0; i < BURST_TICKS; i++)
        begin
            c        = random_item();
            c.opcode = dmsr_pkg::OP_CRUISE;
            send_cmd(c);
        end
        send_cmd(make_cmd(dmsr_pkg::OP_SPEED, 8'h00, 8'h00, 8'd200, 8'd200,
                          dmsr_pkg::DIR_OFF));
        send_cmd(make_cmd(dmsr_pkg::OP_DIRECTION, 8'h00, 8'h00, 8'h00, 8'h00,
                          dmsr_pkg::DIR_FORWARD));
        for (int i = 0; i < BURST_TICKS; i++)
            send_cmd(make_cmd(dmsr_pkg::OP_ACCEL, 8'h00, 8'h00, 8'h00, 8'h00,
                              dmsr_pkg::DIR_OFF));
        quiet = 1'b0;
        drain();
        repeat (10) @(posedge clk);

        $display("Sent %0d commands and checked %0d results, %0d mismatching (%0d shown).",
                 sb.items_seen, sb.results_seen, sb.mismatches,
                 (sb.mismatches < 10) ? sb.mismatches : 10);
        $display("Saw %0d cruise updates, %0d ramp steps, %0d deadband and %0d saturation cases.",
                 sb.cruise_updates, sb.ramp_steps, sb.deadbands, sb.saturations);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### sim.f
rtl/dmsr_pkg.sv
rtl/dmsr_side.sv
rtl/dual_motor_speed_ramp.sv
rtl/dmsr_checker.sv
tb/testbench.sv
